// File: hw/rtl/mpr_pkg.sv
package mpr_pkg;

	// fixed point format of the plane arithmetic
	localparam int FRAC_BITS = 32;
	localparam int WORD_W    = 64;

	// divider chain geometry
	localparam int SPAN_W    = 39;
	localparam int DIM_W     = 13;
	localparam int DIV_CELLS = SPAN_W;

	// one request moving down the divider chain
	typedef struct packed {
		logic              vld;
		logic [SPAN_W-1:0] num;
		logic [SPAN_W-1:0] quo;
		logic [DIM_W-1:0]  rem;
		logic [DIM_W-1:0]  den;
	} dv_t;

endpackage

// File: hw/rtl/mpr_div_cell.sv
module mpr_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  mpr_pkg::dv_t  din,
	output mpr_pkg::dv_t  dout
);

	logic [mpr_pkg::DIM_W:0]   trial;
	logic                      ge;
	logic [mpr_pkg::DIM_W-1:0] rem_nxt;
	logic                      vld_q;
	mpr_pkg::dv_t              pay_q;

	// one restoring step: bring down the next dividend bit and try the divisor
	always_comb begin
		trial   = {din.rem, din.num[mpr_pkg::SPAN_W-1]};
		ge      = (trial >= {1'b0, din.den});
		rem_nxt = ge ? mpr_pkg::DIM_W'(trial - {1'b0, din.den}) : trial[mpr_pkg::DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	// payload hands on to the neighbor every cycle
	always_ff @(posedge clk) begin
		pay_q.vld <= 1'b0;
		pay_q.num <= {din.num[mpr_pkg::SPAN_W-2:0], 1'b0};
		pay_q.quo <= {din.quo[mpr_pkg::SPAN_W-2:0], ge};
		pay_q.rem <= rem_nxt;
		pay_q.den <= din.den;
	end

	always_comb begin
		dout     = pay_q;
		dout.vld = vld_q;
	end

endmodule

// File: hw/rtl/mpr_fxmul.sv
module mpr_fxmul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [mpr_pkg::WORD_W-1:0]  a,
	input  logic signed [mpr_pkg::WORD_W-1:0]  b,
	output logic                               done,
	output logic signed [mpr_pkg::WORD_W-1:0]  res
);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_NEG, M_SAT} mstate_t;

	localparam int PW = 2 * mpr_pkg::WORD_W;
	localparam int HW = mpr_pkg::WORD_W / 2;

	mstate_t                       state_q;
	logic [mpr_pkg::WORD_W-1:0]    ua_q, ub_q, pp_q;
	logic                          neg_q;
	logic [2:0]                    step_q;
	logic [1:0]                    sh_q;
	logic [PW-1:0]                 acc_q;
	logic                          done_q;
	logic signed [mpr_pkg::WORD_W-1:0] res_q;

	logic [HW-1:0]                 ah, bh;
	logic [PW-1:0]                 pp_sh;
	logic signed [PW-1:0]          shifted;
	logic [PW-mpr_pkg::WORD_W:0]   top;
	logic [mpr_pkg::WORD_W-1:0]    ma, mb;

	// magnitudes, halves and shifted partial product
	always_comb begin
		ma = a[mpr_pkg::WORD_W-1] ? mpr_pkg::WORD_W'(-a) : a;
		mb = b[mpr_pkg::WORD_W-1] ? mpr_pkg::WORD_W'(-b) : b;
		ah = step_q[1] ? ua_q[mpr_pkg::WORD_W-1:HW] : ua_q[HW-1:0];
		bh = step_q[0] ? ub_q[mpr_pkg::WORD_W-1:HW] : ub_q[HW-1:0];
		case (sh_q)
			2'd0:    pp_sh = {{mpr_pkg::WORD_W{1'b0}}, pp_q};
			2'd1:    pp_sh = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
			2'd2:    pp_sh = {pp_q, {mpr_pkg::WORD_W{1'b0}}};
			default: pp_sh = '0;
		endcase
		shifted = $signed(acc_q) >>> mpr_pkg::FRAC_BITS;
		top     = shifted[PW-1:mpr_pkg::WORD_W-1];
	end

	// sequencer: four partial products, sign, then renormalise and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			ua_q    <= '0;
			ub_q    <= '0;
			pp_q    <= '0;
			neg_q   <= 1'b0;
			step_q  <= '0;
			sh_q    <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= (state_q == M_SAT);
			case (state_q)
				M_IDLE: begin
					if (start) begin
						ua_q    <= ma;
						ub_q    <= mb;
						neg_q   <= a[mpr_pkg::WORD_W-1] ^ b[mpr_pkg::WORD_W-1];
						acc_q   <= '0;
						step_q  <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					if (step_q != 3'd4) begin
						pp_q <= ah * bh;
						sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
					end
					if (step_q != 3'd0) begin
						acc_q <= acc_q + pp_sh;
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= M_NEG;
					end
				end
				M_NEG: begin
					if (neg_q) begin
						acc_q <= ~acc_q + PW'(1);
					end
					state_q <= M_SAT;
				end
				M_SAT: begin
					if ((&top) || !(|top)) begin
						res_q <= shifted[mpr_pkg::WORD_W-1:0];
					end else if (top[PW-mpr_pkg::WORD_W]) begin
						res_q <= {1'b1, {(mpr_pkg::WORD_W-1){1'b0}}};
					end else begin
						res_q <= {1'b0, {(mpr_pkg::WORD_W-1){1'b1}}};
					end
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: hw/rtl/mandelbrot_pixel_rainbow.sv
// Mandelbrot escape-time pixel engine with rainbow colouring. One request
// (pixel_row, pixel_col) gives one result (pixel_color, escape_count). A pixel
// on the centre row or column returns the white crosshair word without using the
// divider or the iteration. Any other pixel first runs span/width and span/height
// through a 39-cell divider chain, maps the point in S_MAP1 and S_MAP2, then runs
// the z iterations, each paced by the multiplier that forms each 64 x 64 product
// from four 32 x 32 partial products in turn, and colours the count in S_C1 to
// S_C4. The next request is taken once the current result sits in the output
// register. Configuration must be written only while no request is in flight;
// the block itself does not enforce this.
module mandelbrot_pixel_rainbow (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] pixel_row,
	input  logic [11:0] pixel_col,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel_color,
	output logic [15:0] escape_count
);

	localparam int W = mpr_pkg::WORD_W;

	localparam logic [2:0] REG_SPAN   = 3'd0;
	localparam logic [2:0] REG_CX     = 3'd1;
	localparam logic [2:0] REG_CY     = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;
	localparam logic [2:0] REG_LIMIT  = 3'd5;

	localparam logic signed [W-1:0] THREE = W'(3) << mpr_pkg::FRAC_BITS;
	localparam logic [31:0] CROSS_WORD = 32'hFFFF_FFFF;
	localparam logic [15:0] RECIP_360  = 16'd46604;
	localparam logic [10:0] RECIP_60   = 11'd1093;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV0, S_DIV1, S_DIVW, S_MAP1, S_MAP2, S_TEST, S_WAITA,
		S_STARTB, S_WAITB, S_C1, S_C2, S_C3, S_C4, S_FIN
	} state_t;

	// saturating helpers for the loop arithmetic
	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		logic [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1]) begin
			return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		logic [W:0] s;
		s = {x[W-1], x} - {y[W-1], y};
		if (s[W] != s[W-1]) begin
			return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [31:0] hue_pack(input logic [2:0] sec, input logic [7:0] f,
			input logic [7:0] q);
		logic [7:0] r, g, bl;
		case (sec)
			3'd0:    begin r = 8'd255; g = f;      bl = 8'd0;   end
			3'd1:    begin r = q;      g = 8'd255; bl = 8'd0;   end
			3'd2:    begin r = 8'd0;   g = 8'd255; bl = f;      end
			3'd3:    begin r = 8'd0;   g = q;      bl = 8'd255; end
			3'd4:    begin r = f;      g = 8'd0;   bl = 8'd255; end
			3'd5:    begin r = 8'd255; g = 8'd0;   bl = q;      end
			default: begin r = 8'd0;   g = 8'd0;   bl = 8'd0;   end
		endcase
		return {8'd0, bl, g, r};
	endfunction

	// configuration registers
	logic [38:0]        span_q;
	logic signed [39:0] cx_q, cy_q;
	logic [12:0]        width_q, height_q;
	logic [15:0]        limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= 39'h04_0000_0000;
			cx_q     <= '0;
			cy_q     <= '0;
			width_q  <= 13'd1024;
			height_q <= 13'd1024;
			limit_q  <= 16'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPAN:   span_q   <= cfg_data[38:0];
				REG_CX:     cx_q     <= cfg_data;
				REG_CY:     cy_q     <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_LIMIT:  limit_q  <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	state_t             state_q;
	logic [11:0]        row_q, col_q;
	logic [38:0]        ratio_x_q, ratio_y_q;
	logic               got_x_q;
	logic [50:0]        px_q, py_q;
	logic signed [W-1:0] x0_q, y0_q, x_q, y_q, x2_q, y2_q, xt_q;
	logic [15:0]        n_q;
	logic [31:0]        nq_q;
	logic [8:0]         m_q;
	logic [2:0]         sec_q;
	logic [31:0]        color_q;
	logic [15:0]        count_q;
	logic               out_valid_q;
	logic [31:0]        pixel_color_q;
	logic [15:0]        escape_count_q;

	// divider chain: span / width, then span / height in the following cycle
	mpr_pkg::dv_t chain [0:mpr_pkg::DIV_CELLS];

	always_comb begin
		chain[0].vld = (state_q == S_DIV0) || (state_q == S_DIV1);
		chain[0].num = span_q;
		chain[0].quo = '0;
		chain[0].rem = '0;
		if (state_q == S_DIV0) begin
			chain[0].den = (width_q == '0) ? 13'd1 : width_q;
		end else begin
			chain[0].den = (height_q == '0) ? 13'd1 : height_q;
		end
	end

	for (genvar i = 0; i < mpr_pkg::DIV_CELLS; i++) begin : g_div
		mpr_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	// z iteration products
	logic                m0_start, m1_start, m0_done, m1_done;
	logic signed [W-1:0] m0_a, m0_b, m0_res, m1_res, sum2;
	logic                go;

	always_comb begin
		sum2     = sadd(x2_q, y2_q);
		go       = (sum2 < THREE) && (n_q < limit_q);
		m0_start = ((state_q == S_TEST) && go) || (state_q == S_STARTB);
		m1_start = (state_q == S_STARTB);
		m0_a     = (state_q == S_TEST) ? sadd(x_q, x_q) : x_q;
		m0_b     = (state_q == S_TEST) ? y_q : x_q;
	end

	mpr_fxmul u_mul0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m0_start),
		.a      (m0_a),
		.b      (m0_b),
		.done   (m0_done),
		.res    (m0_res)
	);

	mpr_fxmul u_mul1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m1_start),
		.a      (y_q),
		.b      (y_q),
		.done   (m1_done),
		.res    (m1_res)
	);

	// colour arithmetic
	logic [16:0] q360;
	logic [19:0] sm;
	logic [8:0]  sec60;
	logic [5:0]  rr;
	logic [9:0]  f17, q17;
	logic [5:0]  rinv;

	always_comb begin
		q360  = 17'(nq_q[31:24]) * 17'd360;
		sm    = 20'(m_q) * 20'(RECIP_60);
		sec60 = 9'(sec_q) * 9'd60;
		rr    = 6'(m_q - sec60);
		rinv  = 6'd60 - rr;
		f17   = 10'(rr) * 10'd17;
		q17   = 10'(rinv) * 10'd17;
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			row_q          <= '0;
			col_q          <= '0;
			ratio_x_q      <= '0;
			ratio_y_q      <= '0;
			got_x_q        <= 1'b0;
			px_q           <= '0;
			py_q           <= '0;
			x0_q           <= '0;
			y0_q           <= '0;
			x_q            <= '0;
			y_q            <= '0;
			x2_q           <= '0;
			y2_q           <= '0;
			xt_q           <= '0;
			n_q            <= '0;
			nq_q           <= '0;
			m_q            <= '0;
			sec_q          <= '0;
			color_q        <= '0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
			pixel_color_q  <= '0;
			escape_count_q <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						row_q <= pixel_row;
						col_q <= pixel_col;
						if ((pixel_col == width_q[12:1]) || (pixel_row == height_q[12:1])) begin
							color_q <= CROSS_WORD;
							count_q <= '0;
							state_q <= S_FIN;
						end else begin
							got_x_q <= 1'b0;
							state_q <= S_DIV0;
						end
					end
				end
				S_DIV0: state_q <= S_DIV1;
				S_DIV1: state_q <= S_DIVW;
				S_DIVW: begin
					if (chain[mpr_pkg::DIV_CELLS].vld) begin
						if (!got_x_q) begin
							ratio_x_q <= chain[mpr_pkg::DIV_CELLS].quo;
							got_x_q   <= 1'b1;
						end else begin
							ratio_y_q <= chain[mpr_pkg::DIV_CELLS].quo;
							state_q   <= S_MAP1;
						end
					end
				end
				S_MAP1: begin
					px_q    <= ratio_x_q * col_q;
					py_q    <= ratio_y_q * row_q;
					state_q <= S_MAP2;
				end
				S_MAP2: begin
					x0_q    <= W'(px_q) + W'(cx_q) - W'(span_q[38:1]);
					y0_q    <= W'(py_q) + W'(cy_q) - W'(span_q[38:1]);
					x_q     <= '0;
					y_q     <= '0;
					x2_q    <= '0;
					y2_q    <= '0;
					n_q     <= '0;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (go) begin
						xt_q    <= sadd(ssub(x2_q, y2_q), x0_q);
						state_q <= S_WAITA;
					end else begin
						state_q <= S_C1;
					end
				end
				S_WAITA: begin
					if (m0_done) begin
						y_q     <= sadd(m0_res, y0_q);
						x_q     <= xt_q;
						state_q <= S_STARTB;
					end
				end
				S_STARTB: begin
					n_q     <= n_q + 16'd1;
					state_q <= S_WAITB;
				end
				S_WAITB: begin
					if (m0_done) begin
						x2_q    <= m0_res;
						y2_q    <= m1_res;
						state_q <= S_TEST;
					end
				end
				// count mod 360 by reciprocal, then sector and ramp values
				S_C1: begin
					nq_q    <= n_q * RECIP_360;
					state_q <= S_C2;
				end
				S_C2: begin
					m_q     <= 9'(17'(n_q) - q360);
					state_q <= S_C3;
				end
				S_C3: begin
					sec_q   <= sm[18:16];
					state_q <= S_C4;
				end
				S_C4: begin
					color_q <= (n_q < limit_q) ? hue_pack(sec_q, f17[9:2], q17[9:2]) : '0;
					count_q <= n_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						pixel_color_q  <= color_q;
						escape_count_q <= count_q;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign pixel_color  = pixel_color_q;
	assign escape_count = escape_count_q;

`ifndef SYNTHESIS
	a_div_window: assert property (@(posedge clk) disable iff (!arst_n)
		chain[mpr_pkg::DIV_CELLS].vld |-> (state_q == S_DIVW))
		else $error("divider result outside its wait window");
	a_mul_window: assert property (@(posedge clk) disable iff (!arst_n)
		m0_done |-> ((state_q == S_WAITA) || (state_q == S_WAITB)))
		else $error("product done outside a wait state");
	a_pair_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAITB) && m0_done |-> m1_done)
		else $error("square products out of step");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEST) |-> (n_q <= limit_q))
		else $error("iteration count passed the limit");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (state_q != S_IDLE))
		else $error("request taken but sequencer idle");
`endif

endmodule
